### rtl/lj_pair_energy_force_core_defines.svh
// Assertion macros shared by the Lennard-Jones pair core RTL.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef LJ_PAIR_ENERGY_FORCE_CORE_DEFINES_SVH
`define LJ_PAIR_ENERGY_FORCE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LJPEF_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LJPEF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ljpef_pkg.sv
// Shared types and constants of the Lennard-Jones pair energy and force core.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ljpef_pkg;

   localparam int COORD_FRAC_BITS_DEF = 16;

   localparam int IN_W       = 24;
   localparam int MAG_W      = 24;
   localparam int OUT_W      = 48;
   localparam int SIGMA_W    = 16;
   localparam int EPS_W      = 24;
   localparam int RR2_W      = 48;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   // Force prefactor 48 and the energy shift that folds the factor 4 into Q24.24.
   localparam int FORCE_SCALE  = 48;
   localparam int E48_W        = EPS_W + 6;
   localparam int ENERGY_SHIFT = 22;

   localparam logic [SIGMA_W-1:0] SIGMA_RESET = 16'd13926;
   localparam logic [EPS_W-1:0]   EPS_RESET   = 24'd131072;

   localparam logic [OUT_W-1:0] LIM_POS = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] LIM_NEG = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SIGMA   = 4'd0,
      REG_EPSILON = 4'd1
   } csr_reg_type;

   typedef struct packed {
      logic signed [IN_W-1:0] dx;
      logic signed [IN_W-1:0] dy;
      logic signed [IN_W-1:0] dz;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] energy;
      logic signed [OUT_W-1:0] force_x;
      logic signed [OUT_W-1:0] force_y;
      logic signed [OUT_W-1:0] force_z;
      logic                    singular;
      logic                    saturated;
   } rsp_type;

endpackage

### rtl/lj_pair_energy_force_core.sv
// Top level of the Lennard-Jones 12-6 pair energy and force core.
// Depends on ljpef_pkg, ljpef_mul, ljpef_div and the assertion macro header.
//
// Usage:
//   A displacement word (dx, dy, dz) is taken on req_data at every rising edge with
//   start high and busy low. busy is always low: the pipeline takes one word in
//   every cycle, with no gaps between words.
//   Each result word appears on rsp_data for exactly one cycle with rsp_valid high.
//   On its way a word passes the two bit-per-stage dividers (48 stages for
//   sigma^2/rr2 and 72 - COORD_FRAC_BITS stages for the force quotient) and the
//   three chained two-stage multipliers that form s6 and s12.
//   Results leave in the order the words came in; the receiver has no way to stall,
//   so nothing is held back.
//   sigma_q12 (index 0) and epsilon_q16 (index 1) are written on the csr_ channel,
//   which is always ready; write only while no word is in flight. Other indexes
//   are ignored.
//   Synchronous reset empties the pipeline and restores the register defaults.
`timescale 1ns / 1ps
`include "lj_pair_energy_force_core_defines.svh"

module lj_pair_energy_force_core #(
   parameter int COORD_FRAC_BITS = ljpef_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  ljpef_pkg::req_type               req_data,
   output logic                             busy,
   output logic                             rsp_valid,
   output ljpef_pkg::rsp_type               rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ljpef_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ljpef_pkg::CSR_DATA_W-1:0] csr_data
);
   import ljpef_pkg::*;

   localparam int QSH    = 2 * COORD_FRAC_BITS + 8;
   localparam int QNUM_W = 128;
   localparam int Q_W    = 48;
   localparam int QTOP_W = QNUM_W - Q_W;
   localparam int S_W    = 64;
   localparam int EM_W   = E48_W + MAG_W;
   localparam int N_W    = S_W + EM_W;
   localparam int NSH    = 24 - COORD_FRAC_BITS;
   localparam int QB     = OUT_W + NSH;
   localparam int FTOP_W = N_W - QB;
   localparam int EP_W   = S_W + EPS_W;
   localparam int EMAG_W = EP_W - ENERGY_SHIFT;

   typedef struct packed {
      logic [RR2_W-1:0]           rr2;
      logic [2:0][MAG_W-1:0]      mag;
      logic [2:0]                 neg;
      logic [2:0][EM_W-1:0]       em;
   } base_type;

   typedef struct packed {
      logic [Q_W-1:0] q;
      logic           inf;
      base_type       base;
   } m1sb_type;

   typedef struct packed {
      logic     inf;
      base_type base;
   } m2sb_type;

   typedef struct packed {
      logic [Q_W-1:0] s6;
      logic           inf;
      base_type       base;
   } m3sb_type;

   typedef struct packed {
      logic                  dneg;
      logic                  gneg;
      logic                  inf;
      logic [RR2_W-1:0]      rr2;
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
   } fsb_type;

   typedef struct packed {
      logic [EMAG_W-1:0] emag;
      fsb_type           f;
   } dsb_type;

   typedef struct packed {
      logic [OUT_W-1:0] val;
      logic             sat;
   } enc_type;

   // Clamp a magnitude to the output range and apply the sign.
   function automatic enc_type sat_enc(input logic neg, input logic [EMAG_W-1:0] mag,
                                       input logic big);
      enc_type          r;
      logic [OUT_W-1:0] lim;
      logic [OUT_W-1:0] m;
      lim   = neg ? LIM_NEG : LIM_POS;
      r.sat = big || (mag > EMAG_W'(lim));
      m     = r.sat ? lim : mag[OUT_W-1:0];
      r.val = neg ? (OUT_W'(0) - m) : m;
      return r;
   endfunction

   // Configuration registers and values derived from them.
   logic [SIGMA_W-1:0]   sigma_ff;
   logic [EPS_W-1:0]     epsilon_ff;
   logic [2*SIGMA_W-1:0] sigma2_ff;
   logic [E48_W-1:0]     eps48_ff;
   logic [QNUM_W-1:0]    qnum;

   // Front stages.
   logic                  in_v_ff;
   req_type               req_ff;
   logic [2:0][MAG_W-1:0] comp;
   logic [2:0][MAG_W-1:0] mag_in;
   logic [2:0]            neg_in;
   logic                  s2_v_ff;
   logic [2:0][MAG_W-1:0] s2_mag_ff;
   logic [2:0]            s2_neg_ff;
   logic                  s3_v_ff;
   logic [2:0][RR2_W-1:0] s3_sq_ff;
   logic [2:0][EM_W-1:0]  s3_em_ff;
   logic [2:0][MAG_W-1:0] s3_mag_ff;
   logic [2:0]            s3_neg_ff;
   logic                  s4_v_ff;
   logic [RR2_W-1:0]      s4_rr2_ff;
   logic [2:0][EM_W-1:0]  s4_em_ff;
   logic [2:0][MAG_W-1:0] s4_mag_ff;
   logic [2:0]            s4_neg_ff;
   base_type              s4_base;

   // Quotient and power chain.
   logic                 qd_v;
   logic [Q_W-1:0]       qd_q;
   logic                 qd_ovf;
   base_type             qd_sb;
   m1sb_type             m1_in_sb;
   logic                 m1_v;
   logic [2*Q_W-1:0]     m1_p;
   m1sb_type             m1_sb;
   m2sb_type             m2_in_sb;
   logic                 m2_v;
   logic [S_W+Q_W-1:0]   m2_p;
   m2sb_type             m2_sb;
   m3sb_type             m3_in_sb;
   logic                 m3_v;
   logic [2*Q_W-1:0]     m3_p;
   m3sb_type             m3_sb;

   // Difference stage.
   logic [S_W-1:0] s6_w;
   logic [S_W-1:0] s12_w;
   logic [S_W-1:0] half_w;
   logic           dneg_in;
   logic           glow_in;
   logic [S_W-1:0] dmag_in;
   logic [S_W-1:0] gmag_in;
   logic           d_v_ff;
   logic [S_W-1:0] d_dmag_ff;
   logic           d_dneg_ff;
   logic [S_W-1:0] d_gmag_ff;
   logic           d_gneg_ff;
   logic           d_inf_ff;
   base_type       d_base_ff;
   fsb_type        d_fsb;

   // Energy product, force products and force quotients.
   logic [EP_W-1:0]     me_p;
   logic [2:0][N_W-1:0] mf_p;
   logic                mf_v;
   fsb_type             mf_sb;
   dsb_type             dsb_in;
   logic [2:0][QB-1:0]  fd_q;
   logic [2:0]          fd_ovf;
   logic                fd_v;
   dsb_type             fd_sb;

   // Output stage.
   rsp_type fin_in;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // Terms used by the assertions.
   logic sing_out;
   logic zero_out;
   logic sig_wr;
   logic inf_in;
   logic inf_out;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff   <= SIGMA_RESET;
         epsilon_ff <= EPS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SIGMA: begin
               sigma_ff <= csr_data[SIGMA_W-1:0];
            end
            REG_EPSILON: begin
               epsilon_ff <= csr_data[EPS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      sigma2_ff <= (2*SIGMA_W)'(sigma_ff) * (2*SIGMA_W)'(sigma_ff);
      eps48_ff  <= E48_W'(epsilon_ff) * E48_W'(FORCE_SCALE);
   end

   // sigma^2 scaled so that the quotient by rr2 has 32 fraction bits.
   assign qnum = QNUM_W'(sigma2_ff) << QSH;

   assign comp[0] = req_ff.dx;
   assign comp[1] = req_ff.dy;
   assign comp[2] = req_ff.dz;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         neg_in[c] = comp[c][MAG_W-1];
         mag_in[c] = neg_in[c] ? (MAG_W'(0) - comp[c]) : comp[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         d_v_ff  <= 1'b0;
      end else begin
         in_v_ff <= start && !busy;
         s2_v_ff <= in_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         d_v_ff  <= m3_v;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      s2_mag_ff <= mag_in;
      s2_neg_ff <= neg_in;
      for (int c = 0; c < 3; c++) begin
         s3_sq_ff[c] <= RR2_W'(s2_mag_ff[c]) * RR2_W'(s2_mag_ff[c]);
         s3_em_ff[c] <= EM_W'(eps48_ff) * EM_W'(s2_mag_ff[c]);
      end
      s3_mag_ff <= s2_mag_ff;
      s3_neg_ff <= s2_neg_ff;
      s4_rr2_ff <= s3_sq_ff[0] + s3_sq_ff[1] + s3_sq_ff[2];
      s4_em_ff  <= s3_em_ff;
      s4_mag_ff <= s3_mag_ff;
      s4_neg_ff <= s3_neg_ff;
   end

   assign s4_base = '{rr2: s4_rr2_ff, mag: s4_mag_ff, neg: s4_neg_ff, em: s4_em_ff};

   // q = sigma^2 / rr2; a quotient of 2^48 or more makes s12 overflow anyway.
   ljpef_div #(
      .TOP_W (QTOP_W),
      .LOW_W (Q_W),
      .D_W   (RR2_W),
      .SB_W  ($bits(base_type))
   ) u_qdiv (
      .clock  (clock),
      .reset  (reset),
      .in_v   (s4_v_ff),
      .top    (qnum[QNUM_W-1:Q_W]),
      .low    (qnum[Q_W-1:0]),
      .d      (s4_rr2_ff),
      .in_sb  (s4_base),
      .out_v  (qd_v),
      .q      (qd_q),
      .ovf    (qd_ovf),
      .out_sb (qd_sb)
   );

   assign m1_in_sb = '{q: qd_q, inf: qd_ovf, base: qd_sb};

   ljpef_mul #(
      .A_W  (Q_W),
      .B_W  (Q_W),
      .SB_W ($bits(m1sb_type))
   ) u_mul_qq (
      .clock  (clock),
      .reset  (reset),
      .in_v   (qd_v),
      .a      (qd_q),
      .b      (qd_q),
      .in_sb  (m1_in_sb),
      .out_v  (m1_v),
      .p      (m1_p),
      .out_sb (m1_sb)
   );

   assign m2_in_sb = '{inf: m1_sb.inf, base: m1_sb.base};

   ljpef_mul #(
      .A_W  (S_W),
      .B_W  (Q_W),
      .SB_W ($bits(m2sb_type))
   ) u_mul_s6 (
      .clock  (clock),
      .reset  (reset),
      .in_v   (m1_v),
      .a      (m1_p[2*Q_W-1:32]),
      .b      (m1_sb.q),
      .in_sb  (m2_in_sb),
      .out_v  (m2_v),
      .p      (m2_p),
      .out_sb (m2_sb)
   );

   // An s6 of 2^48 or more would square past 64 integer-scaled bits.
   assign m3_in_sb = '{s6:   m2_p[32+Q_W-1:32],
                       inf:  m2_sb.inf || (m2_p[S_W+Q_W-1:32+Q_W] != '0),
                       base: m2_sb.base};

   ljpef_mul #(
      .A_W  (Q_W),
      .B_W  (Q_W),
      .SB_W ($bits(m3sb_type))
   ) u_mul_s12 (
      .clock  (clock),
      .reset  (reset),
      .in_v   (m2_v),
      .a      (m2_p[32+Q_W-1:32]),
      .b      (m2_p[32+Q_W-1:32]),
      .in_sb  (m3_in_sb),
      .out_v  (m3_v),
      .p      (m3_p),
      .out_sb (m3_sb)
   );

   assign s6_w   = S_W'(m3_sb.s6);
   assign s12_w  = m3_p[2*Q_W-1:32];
   assign half_w = s6_w >> 1;

   always_comb begin
      dneg_in = s12_w < s6_w;
      dmag_in = dneg_in ? (s6_w - s12_w) : (s12_w - s6_w);
      glow_in = s12_w < half_w;
      gmag_in = glow_in ? (half_w - s12_w) : (s12_w - half_w);
   end

   always_ff @(posedge clock) begin
      d_dmag_ff <= dmag_in;
      d_dneg_ff <= dneg_in;
      d_gmag_ff <= m3_sb.inf ? '0 : gmag_in;
      d_gneg_ff <= !m3_sb.inf && glow_in;
      d_inf_ff  <= m3_sb.inf;
      d_base_ff <= m3_sb.base;
   end

   assign d_fsb = '{dneg: d_dneg_ff, gneg: d_gneg_ff, inf: d_inf_ff,
                    rr2: d_base_ff.rr2, mag: d_base_ff.mag, neg: d_base_ff.neg};

   ljpef_mul #(
      .A_W  (S_W),
      .B_W  (EPS_W),
      .SB_W (1)
   ) u_mul_energy (
      .clock  (clock),
      .reset  (reset),
      .in_v   (d_v_ff),
      .a      (d_dmag_ff),
      .b      (epsilon_ff),
      .in_sb  (1'b0),
      .out_v  (),
      .p      (me_p),
      .out_sb ()
   );

   assign dsb_in = '{emag: me_p[EP_W-1:ENERGY_SHIFT], f: mf_sb};

   // One lane per force component; the x lane carries the shared sideband.
   for (genvar c = 0; c < 3; c++) begin : g_lane
      if (c == 0) begin : g_lead
         ljpef_mul #(
            .A_W  (S_W),
            .B_W  (EM_W),
            .SB_W ($bits(fsb_type))
         ) u_mul_force (
            .clock  (clock),
            .reset  (reset),
            .in_v   (d_v_ff),
            .a      (d_gmag_ff),
            .b      (d_base_ff.em[c]),
            .in_sb  (d_fsb),
            .out_v  (mf_v),
            .p      (mf_p[c]),
            .out_sb (mf_sb)
         );

         ljpef_div #(
            .TOP_W (FTOP_W),
            .LOW_W (QB),
            .D_W   (RR2_W),
            .SB_W  ($bits(dsb_type))
         ) u_fdiv (
            .clock  (clock),
            .reset  (reset),
            .in_v   (mf_v),
            .top    (mf_p[c][N_W-1:QB]),
            .low    (mf_p[c][QB-1:0]),
            .d      (mf_sb.rr2),
            .in_sb  (dsb_in),
            .out_v  (fd_v),
            .q      (fd_q[c]),
            .ovf    (fd_ovf[c]),
            .out_sb (fd_sb)
         );
      end else begin : g_follow
         ljpef_mul #(
            .A_W  (S_W),
            .B_W  (EM_W),
            .SB_W (1)
         ) u_mul_force (
            .clock  (clock),
            .reset  (reset),
            .in_v   (d_v_ff),
            .a      (d_gmag_ff),
            .b      (d_base_ff.em[c]),
            .in_sb  (1'b0),
            .out_v  (),
            .p      (mf_p[c]),
            .out_sb ()
         );

         ljpef_div #(
            .TOP_W (FTOP_W),
            .LOW_W (QB),
            .D_W   (RR2_W),
            .SB_W  (1)
         ) u_fdiv (
            .clock  (clock),
            .reset  (reset),
            .in_v   (mf_v),
            .top    (mf_p[c][N_W-1:QB]),
            .low    (mf_p[c][QB-1:0]),
            .d      (mf_sb.rr2),
            .in_sb  (1'b0),
            .out_v  (),
            .q      (fd_q[c]),
            .ovf    (fd_ovf[c]),
            .out_sb ()
         );
      end
   end

   always_comb begin
      enc_type     e_enc;
      enc_type     f_enc [3];
      logic        fneg;
      fin_in = '0;
      fneg   = 1'b0;
      // An overflowed s12 counts as positive infinity in both differences.
      if (fd_sb.f.inf) begin
         e_enc = sat_enc(1'b0, '0, 1'b1);
      end else begin
         e_enc = sat_enc(fd_sb.f.dneg, fd_sb.emag, 1'b0);
      end
      for (int c = 0; c < 3; c++) begin
         fneg = (fd_sb.f.gneg == fd_sb.f.neg[c]);
         if (fd_sb.f.mag[c] == '0) begin
            f_enc[c] = '0;
         end else if (fd_sb.f.inf) begin
            f_enc[c] = sat_enc(fneg, '0, 1'b1);
         end else begin
            f_enc[c] = sat_enc(fneg, EMAG_W'(fd_q[c][QB-1:NSH]), fd_ovf[c]);
         end
      end
      if (fd_sb.f.rr2 == '0) begin
         fin_in.singular = 1'b1;
      end else if (epsilon_ff != '0) begin
         fin_in.energy    = e_enc.val;
         fin_in.force_x   = f_enc[0].val;
         fin_in.force_y   = f_enc[1].val;
         fin_in.force_z   = f_enc[2].val;
         fin_in.saturated = e_enc.sat || f_enc[0].sat || f_enc[1].sat || f_enc[2].sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fd_v;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= fin_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign sing_out = rsp_valid_ff && rsp_ff.singular;
   assign zero_out = (rsp_ff.energy == '0) && (rsp_ff.force_x == '0) &&
                     (rsp_ff.force_y == '0) && (rsp_ff.force_z == '0) && !rsp_ff.saturated;
   assign sig_wr   = csr_valid && (csr_index == REG_SIGMA);
   assign inf_in   = fd_v && fd_sb.f.inf && (fd_sb.f.rr2 != '0) && (epsilon_ff != '0);
   assign inf_out  = rsp_valid_ff && rsp_ff.saturated && (rsp_ff.energy == LIM_POS);

   `LJPEF_ASSERT_IMPLIES(a_singular_zero, clock, reset, sing_out, zero_out,
      "singular word carries nonzero outputs")
   `LJPEF_ASSERT_NEXT(a_sigma_write, clock, reset, sig_wr,
      sigma_ff == $past(csr_data[SIGMA_W-1:0]), "sigma register did not take the word")
   `LJPEF_ASSERT_NEXT(a_inf_energy, clock, reset, inf_in, inf_out,
      "overflowed s12 did not clamp the energy")

endmodule

### rtl/ljpef_mul.sv
// Two-stage unsigned multiplier built from 32 by 32 partial products.
// Uses ljpef_pkg for house conventions only; a sideband word rides along.
`timescale 1ns / 1ps

module ljpef_mul #(
   parameter int A_W  = 48,
   parameter int B_W  = 48,
   parameter int SB_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_v,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   input  logic [SB_W-1:0]    in_sb,
   output logic               out_v,
   output logic [A_W+B_W-1:0] p,
   output logic [SB_W-1:0]    out_sb
);
   import ljpef_pkg::*;

   localparam int NA     = (A_W + 31) / 32;
   localparam int NB     = (B_W + 31) / 32;
   localparam int APAD_W = NA * 32;
   localparam int BPAD_W = NB * 32;
   localparam int ACC_W  = APAD_W + BPAD_W;

   logic [APAD_W-1:0] a_pad;
   logic [BPAD_W-1:0] b_pad;

   logic [NA-1:0][NB-1:0][63:0] pp_in;
   logic [NA-1:0][NB-1:0][63:0] pp_ff;
   logic [SB_W-1:0]             sb1_ff;
   logic                        v1_ff;

   logic [ACC_W-1:0]   acc_in;
   logic [A_W+B_W-1:0] p_ff;
   logic [SB_W-1:0]    sb2_ff;
   logic               v2_ff;

   assign a_pad = APAD_W'(a);
   assign b_pad = BPAD_W'(b);

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = 64'(a_pad[32*i +: 32]) * 64'(b_pad[32*j +: 32]);
         end
      end
   end

   // Second stage adds the shifted partial products.
   always_comb begin
      acc_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            acc_in = acc_in + (ACC_W'(pp_ff[i][j]) << (32 * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_v;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      pp_ff  <= pp_in;
      sb1_ff <= in_sb;
      p_ff   <= acc_in[A_W+B_W-1:0];
      sb2_ff <= sb1_ff;
   end

   assign out_v  = v2_ff;
   assign p      = p_ff;
   assign out_sb = sb2_ff;

endmodule

### rtl/ljpef_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
// Uses ljpef_pkg for house conventions only; a sideband word rides along.
`timescale 1ns / 1ps

module ljpef_div #(
   parameter int TOP_W = 80,
   parameter int LOW_W = 48,
   parameter int D_W   = 48,
   parameter int SB_W  = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_v,
   input  logic [TOP_W-1:0] top,
   input  logic [LOW_W-1:0] low,
   input  logic [D_W-1:0]   d,
   input  logic [SB_W-1:0]  in_sb,
   output logic             out_v,
   output logic [LOW_W-1:0] q,
   output logic             ovf,
   output logic [SB_W-1:0]  out_sb
);
   import ljpef_pkg::*;

   logic [LOW_W:0]   v_ff;
   logic [LOW_W:0]   ovf_ff;
   logic [D_W-1:0]   rem_ff [0:LOW_W];
   logic [LOW_W-1:0] low_ff [0:LOW_W];
   logic [LOW_W-1:0] q_ff   [0:LOW_W];
   logic [D_W-1:0]   d_ff   [0:LOW_W];
   logic [SB_W-1:0]  sb_ff  [0:LOW_W];

   logic [D_W:0]     trial  [1:LOW_W];
   logic [D_W:0]     diff   [1:LOW_W];
   logic [LOW_W:1]   take;
   logic [D_W-1:0]   rem_in [1:LOW_W];
   logic [LOW_W-1:0] q_in   [1:LOW_W];

   always_comb begin
      for (int k = 1; k <= LOW_W; k++) begin
         trial[k]  = {rem_ff[k-1], low_ff[k-1][LOW_W-1]};
         diff[k]   = trial[k] - {1'b0, d_ff[k-1]};
         take[k]   = trial[k] >= {1'b0, d_ff[k-1]};
         rem_in[k] = take[k] ? diff[k][D_W-1:0] : trial[k][D_W-1:0];
         q_in[k]   = {q_ff[k-1][LOW_W-2:0], take[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[LOW_W-1:0], in_v};
      end
   end

   // A quotient that needs more than LOW_W bits shows up as top >= d at entry;
   // otherwise top < d and its low bits are the first partial remainder.
   always_ff @(posedge clock) begin
      rem_ff[0] <= top[D_W-1:0];
      low_ff[0] <= low;
      q_ff[0]   <= '0;
      d_ff[0]   <= d;
      ovf_ff[0] <= top >= TOP_W'(d);
      sb_ff[0]  <= in_sb;
      for (int k = 1; k <= LOW_W; k++) begin
         rem_ff[k] <= rem_in[k];
         low_ff[k] <= {low_ff[k-1][LOW_W-2:0], 1'b0};
         q_ff[k]   <= q_in[k];
         d_ff[k]   <= d_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
         sb_ff[k]  <= sb_ff[k-1];
      end
   end

   assign out_v  = v_ff[LOW_W];
   assign q      = q_ff[LOW_W];
   assign ovf    = ovf_ff[LOW_W];
   assign out_sb = sb_ff[LOW_W];

endmodule

### tb/sv/lj_pair_energy_force_checker.sv
// Checker for the Lennard-Jones pair core: mirrors the sigma and epsilon registers,
// predicts each result word from the accepted displacement and compares field by field.
// Depends on ljpef_pkg.
`timescale 1ns / 1ps

module lj_pair_energy_force_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  ljpef_pkg::req_type               req_data,
   input  logic                             rsp_valid,
   input  ljpef_pkg::rsp_type               rsp_data,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [ljpef_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ljpef_pkg::CSR_DATA_W-1:0] csr_data,
   output int                               errors,
   output int                               pending
);
   import ljpef_pkg::*;

   localparam int FRAC = COORD_FRAC_BITS_DEF;
   localparam logic [127:0] TWO64 = 128'd1 << 64;

   logic [SIGMA_W-1:0] sigma_mirror;
   logic [EPS_W-1:0]   eps_mirror;
   rsp_type            expected_words[$];

   // Returns {clamped, value}: the magnitude is clamped to the signed 48-bit range.
   function automatic logic [OUT_W:0] clamp_signed(bit neg, logic [127:0] mag, bit inf);
      logic [127:0] lim;
      logic [127:0] m;
      bit           clamped;
      lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
      m = mag;
      clamped = 1'b0;
      if (inf || mag > lim) begin
         m = lim;
         clamped = 1'b1;
      end
      if (neg) m = -m;
      return {clamped, m[OUT_W-1:0]};
   endfunction

   // floor(a*b / 2^32), with overflow past 64 bits reported
   function automatic logic [64:0] fixmul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> 32;
      return {p >= TWO64, p[63:0]};
   endfunction

   function automatic rsp_type lj_predict(req_type r, logic [SIGMA_W-1:0] sig,
                                          logic [EPS_W-1:0] eps);
      rsp_type              res;
      logic signed [23:0]   comp[3];
      logic [23:0]          mag[3];
      logic [127:0]         rr2, quot, prod, n;
      logic [63:0]          q, s6, s12, half, dmag, gmag;
      logic [64:0]          mr;
      logic [OUT_W:0]       enc;
      logic [OUT_W-1:0]     fval[3];
      bit                   inf, sat, dneg, gneg, fneg;
      res = '0;
      comp[0] = r.dx;
      comp[1] = r.dy;
      comp[2] = r.dz;
      rr2 = '0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = comp[i][23] ? -comp[i] : comp[i];
         rr2 += {104'd0, mag[i]} * {104'd0, mag[i]};
      end
      if (rr2 == 0) begin
         res.singular = 1'b1;
         return res;
      end
      quot = ({96'd0, 32'(sig) * 32'(sig)} << (2 * FRAC + 8)) / rr2;
      inf = quot >= TWO64;
      q = quot[63:0];
      s6 = '0;
      s12 = '0;
      if (!inf) begin
         mr = fixmul(q, q);
         inf = mr[64];
         mr = fixmul(mr[63:0], q);
         inf = inf | mr[64];
         s6 = mr[63:0];
      end
      if (!inf) begin
         mr = fixmul(s6, s6);
         inf = mr[64];
         s12 = mr[63:0];
      end
      if (eps == 0) return res;
      sat = 1'b0;
      if (inf) begin
         enc = clamp_signed(1'b0, '0, 1'b1);
      end else begin
         dneg = s12 < s6;
         dmag = dneg ? s6 - s12 : s12 - s6;
         prod = ({64'd0, dmag} * {104'd0, eps}) >> ENERGY_SHIFT;
         enc = clamp_signed(dneg, prod, 1'b0);
      end
      sat |= enc[OUT_W];
      res.energy = enc[OUT_W-1:0];
      half = s6 >> 1;
      gneg = !inf && s12 < half;
      gmag = inf ? 64'd0 : (gneg ? half - s12 : s12 - half);
      for (int i = 0; i < 3; i++) begin
         fval[i] = '0;
         fneg = (gneg == comp[i][23]);
         if (mag[i] != 0 && (inf || gmag != 0)) begin
            n = (({64'd0, gmag} * {104'd0, eps} * FORCE_SCALE * {104'd0, mag[i]}) / rr2)
                >> (24 - FRAC);
            enc = clamp_signed(fneg, n, inf);
            sat |= enc[OUT_W];
            fval[i] = enc[OUT_W-1:0];
         end
      end
      res.force_x = fval[0];
      res.force_y = fval[1];
      res.force_z = fval[2];
      res.saturated = sat;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         sigma_mirror <= SIGMA_RESET;
         eps_mirror <= EPS_RESET;
         expected_words.delete();
         errors = 0;
      end else begin
         if (start && !busy)
            expected_words.push_back(lj_predict(req_data, sigma_mirror, eps_mirror));
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_SIGMA) sigma_mirror <= csr_data[SIGMA_W-1:0];
            else if (csr_index == REG_EPSILON) eps_mirror <= csr_data[EPS_W-1:0];
         end
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               $display("%0t: result word with none expected: %p", $time, rsp_data);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.energy !== want.energy) begin
                  $display("%0t: energy expected %h actual %h", $time, want.energy,
                           rsp_data.energy);
                  errors++;
               end
               if (rsp_data.force_x !== want.force_x) begin
                  $display("%0t: force_x expected %h actual %h", $time, want.force_x,
                           rsp_data.force_x);
                  errors++;
               end
               if (rsp_data.force_y !== want.force_y) begin
                  $display("%0t: force_y expected %h actual %h", $time, want.force_y,
                           rsp_data.force_y);
                  errors++;
               end
               if (rsp_data.force_z !== want.force_z) begin
                  $display("%0t: force_z expected %h actual %h", $time, want.force_z,
                           rsp_data.force_z);
                  errors++;
               end
               if (rsp_data.singular !== want.singular) begin
                  $display("%0t: singular expected %b actual %b", $time, want.singular,
                           rsp_data.singular);
                  errors++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                           rsp_data.saturated);
                  errors++;
               end
            end
         end
      end
      pending <= expected_words.size();
   end

endmodule

### tb/sv/tb_lj_pair_energy_force_core.sv
// Testbench top for the Lennard-Jones pair core: drives displacement words and
// register writes, and gives the verdict. Depends on ljpef_pkg, the core and the checker.
`timescale 1ns / 1ps

module tb_lj_pair_energy_force_core;
   import ljpef_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 4'd9;
   localparam int DRAIN_CYCLES = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   req_type req_data = '0;
   logic busy, rsp_valid, csr_ready;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int errors, pending;
   int idle_pct;
   int words_sent = 0;
   int settings_used = 0;

   always #6 clock = ~clock;

   lj_pair_energy_force_core dut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data), .busy(busy),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   lj_pair_energy_force_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .errors(errors), .pending(pending)
   );

   // Present one displacement word and hold it until it is taken. busy and ready only
   // change at the rising edge, so their value at the falling edge is the one sampled.
   task automatic send_pair(logic [23:0] x, logic [23:0] y, logic [23:0] z);
      bit taken;
      start <= 1'b1;
      req_data <= '{dx: x, dy: y, dz: z};
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock) taken = !busy;
         @(posedge clock);
      end
      words_sent++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock) taken = csr_ready;
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // Stop sending and let every outstanding word come back before touching registers.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [15:0] sig, logic [23:0] eps);
      drain();
      write_reg(REG_SIGMA, {8'd0, sig});
      write_reg(REG_EPSILON, eps);
      settings_used++;
   endtask

   // A component whose magnitude spans a random number of bits, so that pairs land
   // near sigma as well as far away and very close.
   function automatic logic [23:0] rand_comp();
      int bits;
      logic [23:0] v;
      if ($urandom_range(9) == 0) return 24'($urandom);
      if ($urandom_range(9) == 0) return '0;
      bits = $urandom_range(1, 23);
      v = 24'($urandom) & ((24'd1 << bits) - 24'd1);
      return $urandom_range(1) ? -v : v;
   endfunction

   task automatic random_pairs(int count);
      repeat (count) send_pair(rand_comp(), rand_comp(), rand_comp());
   endtask

   task automatic directed_pairs();
      send_pair(24'd0, 24'd0, 24'd0);
      send_pair(24'h800000, 24'h800000, 24'h800000);
      send_pair(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_pair(24'h7FFFFF, 24'h800000, 24'd0);
      send_pair(24'd1, 24'd0, 24'd0);
      send_pair(24'd0, 24'hFFFFFF, 24'd0);
      send_pair(24'd0, 24'd0, 24'd1);
      send_pair(24'd222822, 24'd0, 24'd0);
      send_pair(24'd0, -24'd222822, 24'd0);
      send_pair(24'd0, 24'd0, 24'd250000);
      send_pair(24'd128000, -24'd128000, 24'd128000);
      send_pair(24'd65536, 24'd0, 24'd0);
      send_pair(24'd16, -24'd16, 24'd16);
      send_pair(24'h400000, 24'h000000, 24'hC00000);
      send_pair(24'h555555, 24'hAAAAAA, 24'h0F0F0F);
   endtask

   initial begin
      idle_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      settings_used = 1;
      directed_pairs();
      random_pairs(300);

      drain();
      write_reg(REG_UNUSED, 24'hFFFFFF);
      configure(16'hFFFF, 24'hFFFFFF);
      directed_pairs();
      idle_pct = 78;
      random_pairs(300);

      configure(16'd4096, 24'd65536);
      idle_pct = 27;
      random_pairs(300);

      configure(16'd0, 24'd200000);
      directed_pairs();
      idle_pct = 0;
      random_pairs(150);

      configure(16'd13926, 24'd0);
      directed_pairs();
      random_pairs(150);

      configure(16'($urandom), 24'($urandom));
      idle_pct = 78;
      random_pairs(300);

      configure(16'($urandom_range(8192, 24576)), 24'($urandom_range(1, 24'hFFFFFF)));
      idle_pct = 27;
      random_pairs(320);

      drain();
      $display("Sent %0d displacement words over %0d register settings,", words_sent,
               settings_used);
      $display("including zero, extreme and near-sigma pairs and zero sigma and epsilon.");
      if (errors == 0)
         $display("tb_lj_pair_energy_force_core: clean");
      else
         $display("tb_lj_pair_energy_force_core: errors");
      $finish;
   end

   initial begin
      #10ms;
      $display("Timed out waiting for result words.");
      $display("tb_lj_pair_energy_force_core: errors");
      $finish;
   end

endmodule
